// ----- hdl/gflm_pkg.sv -----
// Shared types and constants for the group-favoring lock manager.
package gflm_pkg;

    localparam logic [1:0] MODE_CREATE  = 2'd0;
    localparam logic [1:0] MODE_ACQUIRE = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;
    localparam logic [1:0] MODE_DESTROY = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ERROR  = 2'd1;
    localparam logic [1:0] ST_QUEUED = 2'd2;

    localparam logic [6:0] FAVOR_MAX = 7'd100;
    localparam logic [16:0] NONE_MARK = 17'h1FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH,
        S_PICK,
        S_SHIFT,
        S_OUT
    } state_t;

endpackage

// ----- hdl/group_favoring_lock_manager_core.sv -----
// Top level: lock table with per-lock waiter queues held in a synchronous memory.
//
// Usage: one request word enters on the s_axis channel (tdata packs mode,
// lock_index, requester_pid, requester_gid, favor_percent, random_percent).
// Exactly one result word leaves on m_axis (status, created_index,
// handoff_valid, handoff_pid, handoff_gid). Requests are handled one at a time.
// Create, acquire, destroy and a release without waiters pass from the decide
// state straight to the output state.
// A release with waiters scans the waiter queue, one memory read per cycle,
// picks the new owner, then shifts the entries behind the chosen one up by
// one a cycle.
// Per-lock status (active, held, owner, favor, count) sits in flip-flops.
// Reset clears all locks at once; the waiter memory needs no clearing since
// only entries below a lock's waiter count are ever used.
// When the receiver stalls, the result is held in the output register and
// the next request is not taken until that result is delivered.
module group_favoring_lock_manager_core
    import gflm_pkg::*;
#(
    parameter int NUM_LOCKS   = 15,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0], lock_index[5:2], requester_pid[21:6], requester_gid[37:22],
    // favor_percent[44:38], random_percent[51:45], zero fill [55:52]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], created_index[5:2], handoff_valid[6], handoff_pid[22:7],
    // handoff_gid[38:23], zero fill [39]
    output logic [39:0] m_axis_tdata
);

    localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = LW + QW;
    localparam int DEPTH = NUM_LOCKS * (2 ** QW);

    // per-lock state
    logic [NUM_LOCKS-1:0] active_reg;
    logic [NUM_LOCKS-1:0] held_reg;
    logic [16:0]          own_pid_reg [NUM_LOCKS];
    logic [16:0]          own_gid_reg [NUM_LOCKS];
    logic [6:0]           favor_reg   [NUM_LOCKS];
    logic [CW-1:0]        count_reg   [NUM_LOCKS];

    // waiter memory: {pid, gid}
    logic [31:0] wmem [DEPTH];
    logic [31:0] rdata_reg;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wdata;

    state_t state_reg, state_next;

    // latched request
    logic [1:0]  mode_reg;
    logic [3:0]  idx_reg;
    logic [15:0] pid_reg, gid_reg;
    logic [6:0]  fav_reg, rnd_reg;

    // release scan
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] sel_reg, sel_next;
    logic          found_reg, found_next;
    logic [31:0]   head_reg, head_next;
    logic [31:0]   pick_reg, pick_next;

    // result register
    logic [1:0]  st_reg;
    logic [3:0]  cidx_reg;
    logic        hv_reg;
    logic [15:0] hp_reg, hg_reg;

    logic [LW-1:0] li;
    logic          idx_ok;
    logic [CW-1:0] n;
    logic [LW-1:0] free_idx;
    logic          free_found;

    assign li     = idx_reg[LW-1:0];
    assign idx_ok = ({28'd0, idx_reg} < NUM_LOCKS) && active_reg[li];
    assign n      = count_reg[li];

    // find lowest inactive lock
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int k = NUM_LOCKS - 1; k >= 0; k--)
        begin
            if (!active_reg[k])
            begin
                free_idx   = LW'(k);
                free_found = 1'b1;
            end
        end
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (we)
            wmem[waddr] <= wdata;
        rdata_reg <= wmem[raddr];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {1'b0, hg_reg, hp_reg, hv_reg, cidx_reg, st_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_axis_tvalid)
                    state_next = S_DECIDE;
            S_DECIDE:
                if (mode_reg == MODE_RELEASE && idx_ok && held_reg[li]
                    && own_pid_reg[li] == {1'b0, pid_reg} && n != '0)
                    state_next = S_SEARCH;
                else
                    state_next = S_OUT;
            S_SEARCH:
                // rdata holds entry ptr-1 once ptr is nonzero
                if (ptr_reg != '0 && (found_reg || ptr_reg == n))
                    state_next = S_PICK;
            S_PICK:
                state_next = S_SHIFT;
            S_SHIFT:
                if (ptr_reg + CW'(1) >= n)
                    state_next = S_OUT;
            S_OUT:
                if (m_axis_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // scan datapath and memory addresses
    always_comb
    begin
        ptr_next   = ptr_reg;
        sel_next   = sel_reg;
        found_next = found_reg;
        head_next  = head_reg;
        pick_next  = pick_reg;
        we    = 1'b0;
        waddr = {li, QW'(0)};
        raddr = {li, QW'(0)};
        wdata = {pid_reg, gid_reg};
        unique case (state_reg)
            S_DECIDE:
            begin
                ptr_next   = '0;
                found_next = 1'b0;
                if (mode_reg == MODE_ACQUIRE && idx_ok && (held_reg[li] || n != '0)
                    && own_pid_reg[li] != {1'b0, pid_reg} && n < CW'(QUEUE_DEPTH))
                begin
                    we    = 1'b1;
                    waddr = {li, n[QW-1:0]};
                end
            end
            S_SEARCH:
            begin
                raddr = {li, ptr_reg[QW-1:0]};
                if (ptr_reg != '0)
                begin
                    if (ptr_reg == CW'(1))
                        head_next = rdata_reg;
                    if (!found_reg && rdata_reg[15:0] == gid_reg)
                    begin
                        found_next = 1'b1;
                        sel_next   = ptr_reg - CW'(1);
                        pick_next  = rdata_reg;
                    end
                end
                if (!(ptr_reg != '0 && (found_reg || ptr_reg == n)))
                    ptr_next = ptr_reg + CW'(1);
            end
            S_PICK:
            begin
                if (!(found_reg && rnd_reg < favor_reg[li]))
                begin
                    sel_next  = '0;
                    pick_next = head_reg;
                end
                ptr_next = (found_reg && rnd_reg < favor_reg[li]) ? sel_reg : '0;
                raddr    = {li, QW'(ptr_next + CW'(1))};
            end
            S_SHIFT:
            begin
                // rdata holds entry ptr+1; write to ptr, read ptr+2
                // (n already counts one waiter less here)
                if (ptr_reg < n)
                begin
                    we    = 1'b1;
                    waddr = {li, ptr_reg[QW-1:0]};
                    wdata = rdata_reg;
                end
                ptr_next = ptr_reg + CW'(1);
                raddr    = {li, QW'(ptr_reg + CW'(2))};
            end
            default:
            begin
            end
        endcase
    end

    // control and scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        head_reg <= head_next;
        pick_reg <= pick_next;
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            mode_reg <= s_axis_tdata[1:0];
            idx_reg  <= s_axis_tdata[5:2];
            pid_reg  <= s_axis_tdata[21:6];
            gid_reg  <= s_axis_tdata[37:22];
            fav_reg  <= s_axis_tdata[44:38];
            rnd_reg  <= s_axis_tdata[51:45];
        end
    end

    // lock table and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            held_reg   <= '0;
            for (int k = 0; k < NUM_LOCKS; k++)
            begin
                own_pid_reg[k] <= NONE_MARK;
                own_gid_reg[k] <= NONE_MARK;
                favor_reg[k]   <= '0;
                count_reg[k]   <= '0;
            end
            st_reg   <= ST_DONE;
            cidx_reg <= '0;
            hv_reg   <= 1'b0;
            hp_reg   <= '0;
            hg_reg   <= '0;
        end
        else if (state_reg == S_DECIDE)
        begin
            st_reg   <= ST_ERROR;
            cidx_reg <= '0;
            hv_reg   <= 1'b0;
            hp_reg   <= '0;
            hg_reg   <= '0;
            unique case (mode_reg)
                MODE_CREATE:
                    if (fav_reg <= FAVOR_MAX && free_found)
                    begin
                        active_reg[free_idx]  <= 1'b1;
                        favor_reg[free_idx]   <= fav_reg;
                        held_reg[free_idx]    <= 1'b0;
                        own_pid_reg[free_idx] <= NONE_MARK;
                        own_gid_reg[free_idx] <= NONE_MARK;
                        count_reg[free_idx]   <= '0;
                        st_reg   <= ST_DONE;
                        cidx_reg <= 4'(free_idx);
                    end
                MODE_ACQUIRE:
                    if (idx_ok)
                    begin
                        if (!held_reg[li] && n == '0)
                        begin
                            held_reg[li]    <= 1'b1;
                            own_pid_reg[li] <= {1'b0, pid_reg};
                            own_gid_reg[li] <= {1'b0, gid_reg};
                            st_reg <= ST_DONE;
                        end
                        else if (own_pid_reg[li] != {1'b0, pid_reg}
                                 && n < CW'(QUEUE_DEPTH))
                        begin
                            count_reg[li] <= n + CW'(1);
                            st_reg <= ST_QUEUED;
                        end
                    end
                MODE_RELEASE:
                    if (idx_ok && held_reg[li] && own_pid_reg[li] == {1'b0, pid_reg})
                    begin
                        st_reg <= ST_DONE;
                        if (n == '0)
                        begin
                            held_reg[li]    <= 1'b0;
                            own_pid_reg[li] <= NONE_MARK;
                            own_gid_reg[li] <= NONE_MARK;
                        end
                    end
                MODE_DESTROY:
                    if (idx_ok && !held_reg[li] && n == '0)
                    begin
                        active_reg[li]  <= 1'b0;
                        favor_reg[li]   <= '0;
                        own_pid_reg[li] <= NONE_MARK;
                        own_gid_reg[li] <= NONE_MARK;
                        st_reg <= ST_DONE;
                    end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_PICK)
        begin
            own_pid_reg[li] <= {1'b0, pick_next[31:16]};
            own_gid_reg[li] <= {1'b0, pick_next[15:0]};
            count_reg[li]   <= n - CW'(1);
            hv_reg <= 1'b1;
            hp_reg <= pick_next[31:16];
            hg_reg <= pick_next[15:0];
        end
    end

    // checks
    property p_result_held;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty
    a_result_held: assert property (p_result_held) else $error("result changed while stalled");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("input open while result pending");

    a_handoff_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && hv_reg |-> st_reg == ST_DONE) else $error("handoff without done");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_OUT) |-> !we)
        else $error("memory write outside work");

endmodule

// ----- bench/group_favoring_lock_manager_core_test.sv -----
// Testbench for the group-favoring lock manager: directed and random lock traffic checked against a model.
`timescale 1ns / 100ps

module group_favoring_lock_manager_core_test
    import gflm_pkg::*;
;

    localparam int NLOCK   = 15;
    localparam int QDEPTH  = 16;
    localparam int WDOG    = 5000;
    localparam int RAND_N  = 1250;

    // Packed from the top down, so status lands in the lowest bits
    typedef struct packed {
        logic [15:0] hgid;
        logic [15:0] hpid;
        logic        hv;
        logic [3:0]  created;
        logic [1:0]  status;
    } result_t;

    // Scoreboard: predicts one result per request and checks results in order
    class lock_scoreboard;
        bit          active [NLOCK];
        bit          held   [NLOCK];
        logic [16:0] own_p  [NLOCK];
        logic [16:0] own_g  [NLOCK];
        logic [6:0]  favor  [NLOCK];
        int          cnt    [NLOCK];
        logic [15:0] wp     [NLOCK][QDEPTH];
        logic [15:0] wg     [NLOCK][QDEPTH];
        result_t     pending[$];
        int          errors;
        int          checked;
        int          handoffs;
        int          favored;

        function new();
            for (int k = 0; k < NLOCK; k++) begin
                active[k] = 0;
                favor[k] = 0;
                clear_lock(k);
            end
            errors = 0;
            checked = 0;
            handoffs = 0;
            favored = 0;
        endfunction

        function void clear_lock(int k);
            held[k] = 0;
            own_p[k] = NONE_MARK;
            own_g[k] = NONE_MARK;
            cnt[k] = 0;
        endfunction

        // Note an accepted request and queue its expected result
        function void note_request(logic [1:0] mode, logic [3:0] idx, logic [15:0] pid,
                                   logic [15:0] gid, logic [6:0] fav, logic [6:0] rnd);
            result_t r;
            int n;
            int sel;
            bit found;
            r = '0;
            r.status = ST_ERROR;
            if (mode == MODE_CREATE) begin
                if (fav <= FAVOR_MAX) begin
                    for (int k = 0; k < NLOCK; k++) begin
                        if (!active[k]) begin
                            active[k] = 1;
                            favor[k] = fav;
                            clear_lock(k);
                            r.status = ST_DONE;
                            r.created = k[3:0];
                            break;
                        end
                    end
                end
            end else if (idx < NLOCK && active[idx]) begin
                n = cnt[idx];
                if (mode == MODE_ACQUIRE) begin
                    if (!held[idx] && n == 0) begin
                        held[idx] = 1;
                        own_p[idx] = {1'b0, pid};
                        own_g[idx] = {1'b0, gid};
                        r.status = ST_DONE;
                    end else if (own_p[idx] != {1'b0, pid} && n < QDEPTH) begin
                        wp[idx][n] = pid;
                        wg[idx][n] = gid;
                        cnt[idx] = n + 1;
                        r.status = ST_QUEUED;
                    end
                end else if (mode == MODE_RELEASE) begin
                    if (held[idx] && own_p[idx] == {1'b0, pid}) begin
                        r.status = ST_DONE;
                        if (n == 0) begin
                            clear_lock(idx);
                        end else begin
                            sel = 0;
                            found = 0;
                            for (int i = 0; i < n; i++) begin
                                if (wg[idx][i] == gid) begin
                                    sel = i;
                                    found = 1;
                                    break;
                                end
                            end
                            if (!(found && rnd < favor[idx])) sel = 0;
                            if (sel != 0) favored++;
                            r.hv = 1;
                            r.hpid = wp[idx][sel];
                            r.hgid = wg[idx][sel];
                            for (int i = sel; i + 1 < n; i++) begin
                                wp[idx][i] = wp[idx][i + 1];
                                wg[idx][i] = wg[idx][i + 1];
                            end
                            cnt[idx] = n - 1;
                            held[idx] = 1;
                            own_p[idx] = {1'b0, r.hpid};
                            own_g[idx] = {1'b0, r.hgid};
                            handoffs++;
                        end
                    end
                end else begin
                    if (!held[idx] && n == 0) begin
                        active[idx] = 0;
                        favor[idx] = 0;
                        clear_lock(idx);
                        r.status = ST_DONE;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        // Compare one delivered result word with the oldest expectation
        function void check_result(logic [39:0] word);
            result_t got;
            result_t exp;
            got = result_t'(word[38:0]);
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", word);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp || word[39] !== 1'b0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st=%0d ci=%0d hv=%0d pid=%h gid=%h, got st=%0d ci=%0d hv=%0d pid=%h gid=%h",
                             exp.status, exp.created, exp.hv, exp.hpid, exp.hgid,
                             got.status, got.created, got.hv, got.hpid, got.hgid);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;     // mode, lock_index, pid, gid, favor, random, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;     // status, created_index, handoff_valid, pid, gid, zero fill

    lock_scoreboard board;
    bit  stim_done;
    int  idle_cycles = 0;
    int  sent;
    int  directed_n;
    logic [15:0] pid_pool [4];
    logic [15:0] gid_pool [3];

    group_favoring_lock_manager_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Send one request word, after a random gap; valid stays up until the next
    // word or the gap before it
    task automatic send_word(logic [1:0] mode, logic [3:0] idx, logic [15:0] pid,
                             logic [15:0] gid, logic [6:0] fav, logic [6:0] rnd,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {4'b0, rnd, fav, gid, pid, idx, mode};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        board.note_request(mode, idx, pid, gid, fav, rnd);
        sent++;
        @(negedge clk);
    endtask

    // Drive the result side ready with random stalls, and check every word
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (sent > 600 && sent < 750) stall = 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            board.check_result(m_axis_tdata);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("timeout after %0d idle cycles", WDOG);
            $display("group_favoring_lock_manager_core_test: errors");
            $finish;
        end
    end

    initial begin
        logic [1:0]  mode;
        logic [3:0]  idx;
        logic [15:0] pid;
        logic [15:0] gid;
        logic [6:0]  fav;
        logic [6:0]  rnd;
        int          r;
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        sent = 0;
        stim_done = 0;
        board = new();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: bad favor, creates at extremes, owner reacquire, duplicate
        // waiter, favored handoff, wrong releaser, busy destroy, bad index
        send_word(MODE_CREATE,  0, 0, 0, 7'd127, 0);
        send_word(MODE_CREATE,  0, 0, 0, 7'd101, 0);
        send_word(MODE_CREATE,  0, 0, 0, 7'd100, 0);
        send_word(MODE_CREATE,  0, 0, 0, 7'd0, 0);
        send_word(MODE_ACQUIRE, 0, 16'h0000, 16'h0000, 0, 0);
        send_word(MODE_ACQUIRE, 0, 16'h0000, 16'h0001, 0, 0);
        send_word(MODE_ACQUIRE, 0, 16'hFFFF, 16'hFFFF, 0, 0);
        send_word(MODE_ACQUIRE, 0, 16'h1234, 16'h0000, 0, 0);
        send_word(MODE_ACQUIRE, 0, 16'h1234, 16'h0000, 0, 0);
        send_word(MODE_RELEASE, 0, 16'h5555, 16'h0000, 0, 0);
        send_word(MODE_DESTROY, 0, 0, 0, 0, 0);
        send_word(MODE_RELEASE, 0, 16'h0000, 16'h0000, 0, 7'd99);
        send_word(MODE_RELEASE, 0, 16'h1234, 16'h0000, 0, 7'd127);
        send_word(MODE_RELEASE, 1, 0, 0, 0, 0);
        send_word(MODE_ACQUIRE, 4'd15, 0, 0, 0, 0);
        send_word(MODE_RELEASE, 4'd14, 0, 0, 0, 0);
        send_word(MODE_DESTROY, 4'd15, 0, 0, 0, 0);
        send_word(MODE_DESTROY, 1, 0, 0, 0, 0);
        send_word(MODE_DESTROY, 1, 0, 0, 0, 0);
        // Fill every lock, then the table-full error
        for (int k = 0; k < NLOCK; k++) send_word(MODE_CREATE, 0, 0, 0, 7'(k * 7), 0);
        send_word(MODE_CREATE, 0, 0, 0, 7'd50, 0);
        // Fill one queue past its depth
        for (int k = 0; k < QDEPTH + 2; k++)
            send_word(MODE_ACQUIRE, 4'd14, 16'(k + 1), 16'(k % 3), 0, 0, 1);
        directed_n = sent;

        // Random: mostly sane traffic from a small pool of pids and groups
        for (int k = 0; k < 4; k++) pid_pool[k] = 16'($urandom);
        for (int k = 0; k < 3; k++) gid_pool[k] = 16'($urandom);
        for (int n = 0; n < RAND_N; n++) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                idx = 4'($urandom_range(0, 3));
                pid = pid_pool[$urandom_range(0, 3)];
                gid = gid_pool[$urandom_range(0, 2)];
                mode = (r < 5) ? MODE_CREATE : (r < 45) ? MODE_ACQUIRE :
                       (r < 80) ? MODE_RELEASE : MODE_DESTROY;
                // Release by the real owner most of the time
                if (mode == MODE_RELEASE && board.active[idx] && board.held[idx]
                    && $urandom_range(0, 3) != 0)
                    pid = board.own_p[idx][15:0];
                fav = 7'($urandom_range(0, 100));
                rnd = 7'($urandom_range(0, 99));
            end else begin
                mode = 2'($urandom);
                idx  = 4'($urandom);
                pid  = 16'($urandom);
                gid  = 16'($urandom);
                fav  = 7'($urandom);
                rnd  = 7'($urandom);
            end
            send_word(mode, idx, pid, gid, fav, rnd, ($urandom_range(0, 4) == 0));
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;

        // Drain and settle
        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("sent %0d requests (%0d directed), checked %0d results",
                 sent, directed_n, board.checked);
        $display("handoffs %0d, of which %0d went to a group waiter behind the head",
                 board.handoffs, board.favored);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("group_favoring_lock_manager_core_test: clean");
        else
            $display("group_favoring_lock_manager_core_test: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/gflm_pkg.sv
hdl/group_favoring_lock_manager_core.sv
bench/group_favoring_lock_manager_core_test.sv
